// ===== hdl/sgrb_pkg.sv =====
// Shared types and constants of the scaled glyph row blitter.
package sgrb_pkg;

    localparam int GLYPH_COLS = 8;
    localparam int MASK_W     = 32;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int COORD_W    = 13;
    localparam int ADDR_W     = 25;
    localparam int COLOR_W    = 32;
    localparam int SCALE_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE   = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;     // write one font row byte
        logic capture;  // latch the fields of a draw request
        logic start;    // set up counters, address and column clip, fetch row 0
        logic emit;     // load one row write into the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a row this cycle
        logic last;      // current row is the final one of the character
    } t_status;

endpackage

// ===== hdl/sgrb_ram.sv =====
// Generic single write port RAM with a registered read port.
module sgrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sgrb_ctrl.sv =====
// Controller state machine of the glyph blitter: sequences load and draw requests.
module sgrb_ctrl
    import sgrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_action,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_action == ACT_DRAW) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.load    = i_valid && i_action == ACT_LOAD;
                o_cmd.capture = i_valid && i_action == ACT_DRAW;
            end
            ST_SETUP: begin
                o_cmd.start = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/sgrb_datapath.sv =====
// Datapath of the glyph blitter: configuration, font store, row counters and output register.
module sgrb_datapath
    import sgrb_pkg::*;
#(
    parameter int GLYPH_ROWS = 16,
    parameter int MAX_SCALE  = 4,
    parameter int CHAR_COUNT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic [7:0]                i_char_code,
    input  logic [3:0]                i_glyph_row,
    input  logic [7:0]                i_glyph_bits,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic [COLOR_W-1:0]        i_draw_color,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic signed [ADDR_W-1:0]  o_row_address,
    output logic [MASK_W-1:0]         o_pixel_mask,
    output logic [COLOR_W-1:0]        o_write_color,
    output logic                      o_last_row
);

    localparam int CW    = $clog2(CHAR_COUNT);
    localparam int DEPTH = CHAR_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_ROWS);
    localparam int SW    = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    // Configuration registers
    logic [CFG_W-1:0]   r_cfg_width;
    logic [CFG_W-1:0]   r_cfg_height;
    logic [CFG_W-1:0]   r_cfg_pitch;
    logic [SCALE_W-1:0] r_cfg_scale;

    // Draw request state
    logic [CW-1:0]             r_code;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [COLOR_W-1:0]        r_color;
    logic [SCALE_W-1:0]        r_scale;
    logic [MASK_W-1:0]         r_colmask;
    logic [ADDR_W-1:0]         r_addr;
    logic signed [COORD_W:0]   r_py;
    logic [RW-1:0]             r_grow;
    logic [SW-1:0]             r_sub;

    // Output register
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [MASK_W-1:0]   r_out_mask;
    logic [COLOR_W-1:0]  r_out_color;
    logic                r_out_last;

    logic [CW-1:0]             w_code_mod;
    logic [SCALE_W-1:0]        w_scale_eff;
    logic                      w_row_ok;
    logic                      w_ram_we;
    logic [AW-1:0]             w_waddr;
    logic                      w_ram_re;
    logic [AW-1:0]             w_raddr;
    logic [RW:0]               w_rd_row;
    logic [7:0]                w_bits;
    logic                      w_sub_last;
    logic                      w_last;
    logic                      w_row_on;
    logic signed [26:0]        w_prod;
    logic [MASK_W-1:0]         w_colmask;
    logic [MASK_W-1:0]         w_exp [MAX_SCALE];
    logic [MASK_W-1:0]         w_exp_sel;

    // One subtraction wraps the 8-bit character code only while it is below twice CHAR_COUNT.
    assign w_code_mod = (int'(i_char_code) >= CHAR_COUNT) ?
                        CW'(int'(i_char_code) - CHAR_COUNT) : CW'(i_char_code);

    always_comb begin
        if (r_cfg_scale == '0) begin
            w_scale_eff = SCALE_W'(1);
        end else if (int'(r_cfg_scale) > MAX_SCALE) begin
            w_scale_eff = SCALE_W'(MAX_SCALE);
        end else begin
            w_scale_eff = r_cfg_scale;
        end
    end

    assign w_row_ok = int'(i_glyph_row) < GLYPH_ROWS;
    assign w_ram_we = i_cmd.load && w_row_ok;
    assign w_waddr  = AW'(int'(w_code_mod) * GLYPH_ROWS + int'(i_glyph_row));

    assign w_sub_last = (r_sub == SW'(r_scale - SCALE_W'(1)));
    assign w_last     = (r_grow == RW'(GLYPH_ROWS - 1)) && w_sub_last;

    assign w_rd_row = i_cmd.start ? '0 : ({1'b0, r_grow} + (RW+1)'(1));
    assign w_raddr  = AW'(int'(r_code) * GLYPH_ROWS + int'(w_rd_row));
    assign w_ram_re = i_cmd.start || (i_cmd.emit && w_sub_last && !w_last);

    sgrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (i_glyph_bits),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_bits)
    );

    // Horizontal expansion of the font byte for each magnification.
    for (genvar gs = 0; gs < MAX_SCALE; gs++) begin : g_scale
        for (genvar gk = 0; gk < MASK_W; gk++) begin : g_bit
            if (gk < GLYPH_COLS * (gs + 1)) begin : g_on
                localparam int SRC_BIT = GLYPH_COLS - 1 - gk / (gs + 1);
                assign w_exp[gs][gk] = w_bits[SRC_BIT];
            end else begin : g_off
                assign w_exp[gs][gk] = 1'b0;
            end
        end
    end

    always_comb begin
        w_exp_sel = '0;
        for (int i = 0; i < MAX_SCALE; i++) begin
            if (r_scale == SCALE_W'(i + 1)) begin
                w_exp_sel = w_exp[i];
            end
        end
    end

    // Column clipping is fixed for the whole character and is worked out once.
    always_comb begin
        logic signed [COORD_W+1:0] v_px;
        w_colmask = '0;
        for (int k = 0; k < MASK_W; k++) begin
            v_px = $signed({r_x[COORD_W-1], r_x[COORD_W-1], r_x}) + (COORD_W+2)'(k);
            w_colmask[k] = (6'(k) < {r_scale, 3'b000}) && !v_px[COORD_W+1]
                           && ($unsigned(v_px) < (COORD_W+2)'(r_cfg_width));
        end
    end

    assign w_prod   = r_y * $signed({1'b0, r_cfg_pitch});
    assign w_row_on = !r_py[COORD_W] && ($unsigned(r_py) < (COORD_W+1)'(r_cfg_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(640);
            r_cfg_height <= CFG_W'(480);
            r_cfg_pitch  <= CFG_W'(640);
            r_cfg_scale  <= SCALE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_ROW_PITCH:     r_cfg_pitch  <= i_cfg_data;
                CFG_GLYPH_SCALE:   r_cfg_scale  <= i_cfg_data[SCALE_W-1:0];
                default:           r_cfg_width  <= r_cfg_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code  <= w_code_mod;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_color <= i_draw_color;
            r_scale <= w_scale_eff;
        end
        if (i_cmd.start) begin
            r_colmask <= w_colmask;
            r_addr    <= w_prod[ADDR_W-1:0] + {{(ADDR_W-COORD_W){r_x[COORD_W-1]}}, r_x};
            r_py      <= {r_y[COORD_W-1], r_y};
        end else if (i_cmd.emit) begin
            r_addr <= r_addr + {{(ADDR_W-CFG_W){1'b0}}, r_cfg_pitch};
            r_py   <= r_py + (COORD_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow <= '0;
            r_sub  <= '0;
        end else if (i_cmd.start) begin
            r_grow <= '0;
            r_sub  <= '0;
        end else if (i_cmd.emit) begin
            if (w_sub_last) begin
                r_sub  <= '0;
                r_grow <= r_grow + RW'(1);
            end else begin
                r_sub <= r_sub + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_addr  <= w_row_on ? r_addr : '0;
            r_out_mask  <= w_row_on ? (w_exp_sel & r_colmask) : '0;
            r_out_color <= r_color;
            r_out_last  <= w_last;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_status.last     = w_last;

    assign o_valid       = r_out_valid;
    assign o_row_address = $signed(r_out_addr);
    assign o_pixel_mask  = r_out_mask;
    assign o_write_color = r_out_color;
    assign o_last_row    = r_out_last;

endmodule

// ===== hdl/scaled_glyph_row_blitter_top.sv =====
// Top level of the scaled glyph row blitter: controller and datapath.
// A load request is taken in the idle state and produces no row write.
// A draw request passes through acceptance, then setup of the start address multiply and the
// first font store read, then GLYPH_ROWS * scale row writes, one per cycle while not stalled.
// The first row write is registered in ST_EMIT after ST_SETUP; output stalls hold the sequence.
// Reset is synchronous and active low; the font store is not cleared and must be loaded first.
module scaled_glyph_row_blitter_top
    import sgrb_pkg::*;
#(
    parameter int GLYPH_ROWS = 16,
    parameter int MAX_SCALE  = 4,
    parameter int CHAR_COUNT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic [7:0]                i_char_code,
    input  logic [3:0]                i_glyph_row,
    input  logic [7:0]                i_glyph_bits,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic [COLOR_W-1:0]        i_draw_color,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [ADDR_W-1:0]  o_row_address,
    output logic [MASK_W-1:0]         o_pixel_mask,
    output logic [COLOR_W-1:0]        o_write_color,
    output logic                      o_last_row
);

    t_cmd    w_cmd;
    t_status w_status;

    sgrb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    sgrb_datapath #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .MAX_SCALE  (MAX_SCALE),
        .CHAR_COUNT (CHAR_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_char_code   (i_char_code),
        .i_glyph_row   (i_glyph_row),
        .i_glyph_bits  (i_glyph_bits),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_draw_color  (i_draw_color),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_row_address (o_row_address),
        .o_pixel_mask  (o_pixel_mask),
        .o_write_color (o_write_color),
        .o_last_row    (o_last_row)
    );

endmodule
